[rtl/cdfs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdfs_pkg
// shared constants and control types for the cdf table category sampler
// ----------------------------------------------------------------------------
package cdfs_pkg;

    localparam int MAX_CATEGORIES = 256;
    localparam int FRACTION_BITS  = 32;
    localparam int TABLE_DEPTH    = MAX_CATEGORIES - 1;
    localparam int IDX_W          = $clog2(MAX_CATEGORIES);
    localparam int COUNT_W        = IDX_W + 1;

    // input tdata: entry_index, boundary_value, uniform_draw
    localparam int S_FIELDS_W     = IDX_W + 2 * FRACTION_BITS;
    localparam int S_TDATA_W      = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W      = ((IDX_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(MAX_CATEGORIES);

    // operation codes carried on tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_SEARCH = 2'b10
    } state_t;

    typedef struct packed {
        logic wr_entry;   // write one boundary entry
        logic start;      // latch draw, set search bounds, issue first read
        logic step;       // one compare and halving step
        logic load_out;   // move final index to the output register
    } cmd_t;

    typedef struct packed {
        logic done;       // search bounds have met
    } sts_t;

endpackage
`default_nettype wire

[rtl/cdf_table_category_sampler_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdf_table_category_sampler_top
// inverse-cdf category sampler over a table of ascending boundaries
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one item per transfer. tuser selects the operation:
//   load writes boundary_value into entry entry_index (indexes past the
//   table are dropped), draw searches the table with uniform_draw.
//   m_axis returns one category per draw; loads return nothing.
//   cfg carries category_count; write it only while the block is idle.
// sequencing:
//   a load is taken in the idle state, and the next item can follow directly.
//   a draw is taken, the search steps until its bounds meet, and the category
//   then moves to the result register once that register is free. the next
//   item is taken only when the block is back in idle, so a draw finishes
//   before the next item goes in. the search does one table read and
//   one compare per cycle on the single read port.
// reset:
//   aresetn (synchronous, active low) clears the sequencer, the result
//   valid and sets category_count to 256. table contents are not cleared;
//   every entry must be loaded before a draw reaches it.
// stalls:
//   the result register holds a finished category until m_axis_tready, the
//   block keeps taking items meanwhile; a second draw finishes its search and
//   then waits for the result register to free up.
// ----------------------------------------------------------------------------
module cdf_table_category_sampler_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [7:0] entry_index, [39:8] boundary_value, [71:40] uniform_draw
    input  wire logic [cdfs_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [0] operation
    input  wire logic                              s_axis_tuser,
    // result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [7:0] category
    output logic [cdfs_pkg::M_TDATA_W-1:0]         m_axis_tdata,
    // configuration write
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [cdfs_pkg::COUNT_W-1:0]      cfg_data
);

    localparam int BND_LO  = cdfs_pkg::IDX_W;
    localparam int DRAW_LO = cdfs_pkg::IDX_W + cdfs_pkg::FRACTION_BITS;

    cdfs_pkg::cmd_t                 cmd;
    cdfs_pkg::sts_t                 sts;
    logic [cdfs_pkg::IDX_W-1:0]     category;

    // register accepted at any time
    assign cfg_ready = 1'b1;

    cdfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_op    (s_axis_tuser),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    cdfs_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .in_index    (s_axis_tdata[cdfs_pkg::IDX_W-1:0]),
        .in_boundary (s_axis_tdata[BND_LO +: cdfs_pkg::FRACTION_BITS]),
        .in_draw     (s_axis_tdata[DRAW_LO +: cdfs_pkg::FRACTION_BITS]),
        .cmd         (cmd),
        .sts         (sts),
        .category    (category)
    );

    // category padded to whole bytes
    assign m_axis_tdata = cdfs_pkg::M_TDATA_W'(category);

endmodule
`default_nettype wire

[rtl/cdfs_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdfs_datapath
// boundary table, search bounds, comparator and result register
// ----------------------------------------------------------------------------
module cdfs_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [cdfs_pkg::COUNT_W-1:0]        cfg_data,
    input  wire logic [cdfs_pkg::IDX_W-1:0]          in_index,
    input  wire logic [cdfs_pkg::FRACTION_BITS-1:0]  in_boundary,
    input  wire logic [cdfs_pkg::FRACTION_BITS-1:0]  in_draw,
    input  wire cdfs_pkg::cmd_t                      cmd,
    output cdfs_pkg::sts_t                           sts,
    output logic [cdfs_pkg::IDX_W-1:0]               category
);

    logic [cdfs_pkg::FRACTION_BITS-1:0] table_mem [0:cdfs_pkg::TABLE_DEPTH-1];

    logic [cdfs_pkg::COUNT_W-1:0]       count_reg;
    logic [cdfs_pkg::IDX_W-1:0]         lo_reg, lo_next;
    logic [cdfs_pkg::IDX_W-1:0]         hi_reg, hi_next;
    logic [cdfs_pkg::IDX_W-1:0]         mid_reg, mid_next;
    logic [cdfs_pkg::FRACTION_BITS-1:0] draw_reg, draw_next;
    logic [cdfs_pkg::FRACTION_BITS-1:0] rdata_reg;
    logic [cdfs_pkg::IDX_W-1:0]         cat_reg;
    logic [cdfs_pkg::IDX_W-1:0]         hi_init;
    logic [cdfs_pkg::IDX_W:0]           bound_sum;
    logic                               rd_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= cdfs_pkg::COUNT_RESET;
        end else if (cfg_we) begin
            count_reg <= cfg_data;
        end
    end

    // last searchable index: count-1, saturated, zero for a bad count
    always_comb begin
        if (count_reg < cdfs_pkg::COUNT_W'(2)) begin
            hi_init = '0;
        end else if (count_reg > cdfs_pkg::COUNT_W'(cdfs_pkg::MAX_CATEGORIES)) begin
            hi_init = cdfs_pkg::IDX_W'(cdfs_pkg::TABLE_DEPTH);
        end else begin
            hi_init = cdfs_pkg::IDX_W'(count_reg - cdfs_pkg::COUNT_W'(1));
        end
    end

    always_comb begin
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        draw_next = draw_reg;
        if (cmd.start) begin
            lo_next   = '0;
            hi_next   = hi_init;
            draw_next = in_draw;
        end else if (cmd.step) begin
            if (draw_reg < rdata_reg) begin
                hi_next = mid_reg;
            end else begin
                lo_next = mid_reg + cdfs_pkg::IDX_W'(1);
            end
        end
        bound_sum = {1'b0, lo_next} + {1'b0, hi_next};
        mid_next  = bound_sum[cdfs_pkg::IDX_W:1];
        rd_en     = (cmd.start || cmd.step) && (lo_next < hi_next);
    end

    always_ff @(posedge aclk) begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        draw_reg <= draw_next;
        if (cmd.load_out) begin
            cat_reg <= lo_reg;
        end
    end

    // table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.wr_entry && (in_index < cdfs_pkg::IDX_W'(cdfs_pkg::TABLE_DEPTH))) begin
            table_mem[in_index] <= in_boundary;
        end
        if (rd_en) begin
            rdata_reg <= table_mem[mid_next];
        end
    end

    assign sts.done = (lo_reg >= hi_reg);
    assign category = cat_reg;

endmodule
`default_nettype wire

[rtl/cdfs_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdfs_ctrl
// sequencer for table loads and the binary search of a draw
// ----------------------------------------------------------------------------
module cdfs_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    input  wire logic           s_op,
    output logic                s_ready,
    output logic                m_valid,
    input  wire logic           m_ready,
    input  wire cdfs_pkg::sts_t sts,
    output cdfs_pkg::cmd_t      cmd
);

    cdfs_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             out_free;

    assign s_ready  = (state_reg == cdfs_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            cdfs_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_op == cdfs_pkg::OP_DRAW) begin
                        cmd.start  = 1'b1;
                        state_next = cdfs_pkg::ST_SEARCH;
                    end else begin
                        cmd.wr_entry = 1'b1;
                    end
                end
            end
            cdfs_pkg::ST_SEARCH: begin
                if (!sts.done) begin
                    cmd.step = 1'b1;
                end else if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = cdfs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cdfs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= cdfs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

    // a result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_ready))
        else $error("result register overwritten while still held");

    // a draw always enters the search
    a_start_search: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> (state_reg == cdfs_pkg::ST_SEARCH))
        else $error("draw accepted without entering search");

    // a new result only appears at the end of a search
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == cdfs_pkg::ST_SEARCH && sts.done))
        else $error("result raised outside search completion");

    // a step never runs once the bounds have met
    a_step_live: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> !sts.done)
        else $error("search step issued after completion");

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the cdf table category sampler: boundary loads and
// draws go in on the input stream, every returned category is compared with a
// typed-in value or a bit-exact search over a local copy of the boundary table
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 24;      // longer than the longest search
    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 85;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_LOAD,
        ROW_DRAW
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [7:0]  idx;
        logic [31:0] value;   // count, boundary or draw depending on kind
        bit          pinned;  // category typed in below
        logic [7:0]  cat;
    } row_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [cdfs_pkg::S_TDATA_W-1:0]   s_axis_tdata;
    logic                             s_axis_tuser;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [cdfs_pkg::M_TDATA_W-1:0]   m_axis_tdata;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [cdfs_pkg::COUNT_W-1:0]     cfg_data;

    // local view of the block: boundary copy, category count, pending results
    logic [cdfs_pkg::FRACTION_BITS-1:0] bnd_tbl [cdfs_pkg::TABLE_DEPTH];
    logic [cdfs_pkg::COUNT_W-1:0]       cat_count;
    logic [7:0]                         cat_due_q [$];

    // typed-in category travelling with the item on the bus
    bit          item_pinned;
    logic [7:0]  item_pin_cat;

    int  mismatches;
    int  cycle_cnt;
    bit  idle_on;
    int  hold_reqs;
    int  hold_served;
    int  hold_left;
    int  stall_left;

    cdf_table_category_sampler_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #1 aclk = ~aclk;

    // upper-bound binary search (first boundary above the draw) over the first count-1 boundaries
    function automatic logic [7:0] pick_category(
            input logic [cdfs_pkg::FRACTION_BITS-1:0] u);
        int eff;
        int lo;
        int hi;
        int mid;
        eff = (cat_count > cdfs_pkg::COUNT_W'(cdfs_pkg::MAX_CATEGORIES))
              ? cdfs_pkg::MAX_CATEGORIES : int'(cat_count);
        if (eff < 2) begin
            return 8'd0;
        end
        lo = 0;
        hi = eff - 1;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (mid < cdfs_pkg::TABLE_DEPTH && u < bnd_tbl[mid]) begin
                hi = mid;
            end else begin
                lo = mid + 1;
            end
        end
        return 8'(lo);
    endfunction

    // result check first, then the input transfer of the same edge
    always @(posedge aclk) begin
        logic [7:0] exp_cat;
        logic [7:0] idx;
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("cdf_table_category_sampler_top regression: fail");
            $finish;
        end
        if (!aresetn) begin
            cat_count = cdfs_pkg::COUNT_W'(cdfs_pkg::MAX_CATEGORIES);
            cat_due_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (cat_due_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("category %0d returned with no draw pending", m_axis_tdata);
                end else begin
                    exp_cat = cat_due_q.pop_front();
                    if (m_axis_tdata !== cdfs_pkg::M_TDATA_W'(exp_cat)) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("category mismatch: expected %0d got %0d",
                                     exp_cat, m_axis_tdata);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                idx = s_axis_tdata[cdfs_pkg::IDX_W-1:0];
                if (s_axis_tuser == cdfs_pkg::OP_DRAW) begin
                    if (item_pinned)
                        cat_due_q.push_back(item_pin_cat);
                    else
                        cat_due_q.push_back(pick_category(
                            s_axis_tdata[cdfs_pkg::IDX_W+cdfs_pkg::FRACTION_BITS +:
                                         cdfs_pkg::FRACTION_BITS]));
                end else if (idx < cdfs_pkg::TABLE_DEPTH) begin
                    bnd_tbl[idx] = s_axis_tdata[cdfs_pkg::IDX_W +: cdfs_pkg::FRACTION_BITS];
                end
            end
            if (cfg_valid && cfg_ready)
                cat_count = cfg_data;
        end
    end

    // result side: random stall bursts, plus a long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready = 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready = 1'b0;
            hold_left--;
        end else if (hold_served != hold_reqs) begin
            hold_served++;
            hold_left = HOLD_CYCLES - 1;
            m_axis_tready = 1'b0;
        end else if (stall_left > 0) begin
            m_axis_tready = 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(5, 0) == 0) begin
            stall_left = $urandom_range(14, 0);
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    // one item on the input stream; starts and ends at a falling edge,
    // leaves tvalid high so a following item can go out back to back
    task automatic push_item(input logic op, input logic [7:0] idx,
                             input logic [31:0] bv, input logic [31:0] ud,
                             input bit pin, input logic [7:0] pin_cat);
        int gap;
        if (idle_on && $urandom_range(3, 0) == 0) begin
            gap = $urandom_range(15, 1);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = cdfs_pkg::S_TDATA_W'({ud, bv, idx});
        item_pinned   = pin;
        item_pin_cat  = pin_cat;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // stop sending and let every pending category come back
    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (cat_due_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_count(input logic [cdfs_pkg::COUNT_W-1:0] v);
        settle();
        cfg_valid = 1'b1;
        cfg_data  = v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
        cfg_data  = cdfs_pkg::COUNT_W'($urandom);
    endtask

    // entries 0..n-1 with a non-decreasing random staircase, some flat steps
    task automatic fill_ascending(input int n);
        longint      acc;
        int unsigned step_max;
        int          i;
        step_max = 32'hFFFF_FFFF / (n + 1);
        acc = ($urandom_range(3, 0) == 0) ? 0 : longint'($urandom_range(step_max, 0));
        for (i = 0; i < n; i++) begin
            push_item(cdfs_pkg::OP_LOAD, 8'(i), acc[31:0], $urandom, 1'b0, 8'd0);
            if ($urandom_range(9, 0) != 0)
                acc += longint'($urandom_range(2 * step_max, 1));
            if (acc > 64'hFFFF_FFFF)
                acc = 64'hFFFF_FFFF;
        end
    endtask

    initial begin
        row_t        steps [$];
        int          p;
        int          n;
        int          k;
        int          eff;
        int unsigned new_cnt;
        bit          ordered;
        logic [7:0]  idx;
        logic [31:0] v;
        logic [31:0] lo_b;
        logic [31:0] hi_b;

        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = cdfs_pkg::OP_LOAD;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        item_pinned   = 1'b0;
        item_pin_cat  = 8'd0;
        mismatches    = 0;
        cycle_cnt     = 0;
        idle_on       = 1'b1;
        hold_reqs     = 0;
        hold_served   = 0;
        hold_left     = 0;
        stall_left    = 0;
        foreach (bnd_tbl[i]) bnd_tbl[i] = '0;

        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // every entry written before any draw can reach it; the draws that
        // follow run with the count left by reset
        fill_ascending(cdfs_pkg::TABLE_DEPTH);
        for (k = 0; k < 4; k++)
            push_item(cdfs_pkg::OP_DRAW, 8'($urandom), $urandom, $urandom, 1'b0, 8'd0);

        // directed rows
        steps.push_back('{ROW_CFG,  8'd0,   32'd2,          1'b0, 8'd0});
        steps.push_back('{ROW_LOAD, 8'd0,   32'h8000_0000, 1'b0, 8'd0});
        steps.push_back('{ROW_DRAW, 8'd0,   32'h0000_0000, 1'b1, 8'd0});
        steps.push_back('{ROW_DRAW, 8'd0,   32'h7FFF_FFFF, 1'b1, 8'd0});
        steps.push_back('{ROW_DRAW, 8'd0,   32'h8000_0000, 1'b1, 8'd1});
        steps.push_back('{ROW_DRAW, 8'd0,   32'hFFFF_FFFF, 1'b1, 8'd1});
        // load past the table is dropped
        steps.push_back('{ROW_LOAD, 8'd255, 32'h0000_0000, 1'b0, 8'd0});
        steps.push_back('{ROW_DRAW, 8'd0,   32'h8000_0000, 1'b1, 8'd1});
        // last entry written although the count does not use it
        steps.push_back('{ROW_LOAD, 8'd254, 32'hFFFF_FFFF, 1'b0, 8'd0});
        // counts below two always give category zero
        steps.push_back('{ROW_CFG,  8'd0,   32'd0,          1'b0, 8'd0});
        steps.push_back('{ROW_DRAW, 8'd0,   32'hFFFF_FFFF, 1'b1, 8'd0});
        steps.push_back('{ROW_CFG,  8'd0,   32'd1,          1'b0, 8'd0});
        steps.push_back('{ROW_DRAW, 8'd0,   32'h0000_0000, 1'b1, 8'd0});
        steps.push_back('{ROW_CFG,  8'd0,   32'd3,          1'b0, 8'd0});
        steps.push_back('{ROW_LOAD, 8'd1,   32'hC000_0000, 1'b0, 8'd0});
        steps.push_back('{ROW_DRAW, 8'd0,   32'h9000_0000, 1'b1, 8'd1});
        steps.push_back('{ROW_DRAW, 8'd0,   32'hFFFF_FFFF, 1'b1, 8'd2});
        steps.push_back('{ROW_DRAW, 8'd0,   32'h0000_0000, 1'b1, 8'd0});
        // table no longer ascending
        steps.push_back('{ROW_LOAD, 8'd1,   32'h0000_0000, 1'b0, 8'd0});
        steps.push_back('{ROW_DRAW, 8'd0,   32'h1000_0000, 1'b0, 8'd0});
        // count above the maximum saturates
        steps.push_back('{ROW_CFG,  8'd0,   32'd511,        1'b0, 8'd0});
        steps.push_back('{ROW_DRAW, 8'd0,   32'hFFFF_FFFF, 1'b1, 8'd255});
        steps.push_back('{ROW_DRAW, 8'd0,   32'h0000_0000, 1'b0, 8'd0});
        steps.push_back('{ROW_CFG,  8'd0,   32'd256,        1'b0, 8'd0});
        steps.push_back('{ROW_DRAW, 8'd0,   32'h4000_0000, 1'b0, 8'd0});

        foreach (steps[i]) begin
            case (steps[i].kind)
                ROW_CFG: begin
                    write_count(cdfs_pkg::COUNT_W'(steps[i].value));
                end
                ROW_LOAD: begin
                    push_item(cdfs_pkg::OP_LOAD, steps[i].idx, steps[i].value, $urandom,
                              1'b0, 8'd0);
                end
                default: begin
                    push_item(cdfs_pkg::OP_DRAW, 8'($urandom), $urandom, steps[i].value,
                              steps[i].pinned, steps[i].cat);
                end
            endcase
        end

        // random phases, each under its own count; phase 5 and the last one without idling
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: new_cnt = 511;
                1: new_cnt = 2;
                2: new_cnt = 256;
                3: new_cnt = $urandom_range(255, 4);
                4: new_cnt = 257 + $urandom_range(254, 0);
                5: new_cnt = 3;
                6: new_cnt = $urandom_range(1, 0);
                7: new_cnt = $urandom_range(511, 0);
                8: new_cnt = $urandom_range(256, 2);
                default: new_cnt = 256;
            endcase
            write_count(cdfs_pkg::COUNT_W'(new_cnt));
            idle_on = (p != PHASES - 1) && (p != 5);
            eff = (new_cnt > cdfs_pkg::MAX_CATEGORIES) ? cdfs_pkg::MAX_CATEGORIES
                                                       : int'(new_cnt);
            ordered = ($urandom_range(2, 0) != 0);
            if (ordered && eff >= 2 && eff <= 64)
                fill_ascending(eff - 1);
            // let the result side sit still while draws pile up behind it
            if (p == 2)
                hold_reqs++;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n < 40) begin
                    push_item(cdfs_pkg::OP_DRAW, 8'($urandom), $urandom, $urandom,
                              1'b0, 8'd0);
                end else if ($urandom_range(9, 0) < 3) begin
                    if ($urandom_range(19, 0) == 0) begin
                        idx = 8'd255;
                        v   = $urandom;
                    end else begin
                        idx = 8'($urandom_range(eff >= 2 ? eff - 2
                                                         : cdfs_pkg::TABLE_DEPTH - 1, 0));
                        if (ordered) begin
                            lo_b = (idx > 0) ? bnd_tbl[idx - 1] : 32'h0;
                            hi_b = (idx < cdfs_pkg::TABLE_DEPTH - 1) ? bnd_tbl[idx + 1]
                                                                     : 32'hFFFF_FFFF;
                            v = (lo_b <= hi_b) ? $urandom_range(hi_b, lo_b) : $urandom;
                        end else begin
                            v = $urandom;
                        end
                    end
                    push_item(cdfs_pkg::OP_LOAD, idx, v, $urandom, 1'b0, 8'd0);
                end else begin
                    case ($urandom_range(9, 0))
                        0: v = 32'h0;
                        1: v = 32'hFFFF_FFFF;
                        2, 3, 4: begin
                            k = $urandom_range(eff >= 2 ? eff - 2 : 0, 0);
                            v = bnd_tbl[k] + 32'($signed($urandom_range(2, 0)) - 1);
                        end
                        default: v = $urandom;
                    endcase
                    push_item(cdfs_pkg::OP_DRAW, 8'($urandom), $urandom, v, 1'b0, 8'd0);
                end
            end
        end

        settle();
        if (mismatches == 0 && cat_due_q.size() == 0) begin
            $display("cdf_table_category_sampler_top regression: pass");
        end else begin
            $display("cdf_table_category_sampler_top regression: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/cdfs_pkg.sv
rtl/cdfs_datapath.sv
rtl/cdfs_ctrl.sv
rtl/cdf_table_category_sampler_top.sv
tb/sv/tb_top.sv
